[design/crgl_pkg.sv]
// Shared types, constants and helpers of the color region growing labeler.
// No dependencies; crgl_engine and the top level import this package.
`default_nettype none
package crgl_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(NPIX);
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int CW         = AW + 1;

  localparam logic [7:0] SMALL_MARK = 8'hFF;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_WIDTH     = 3'd0;
  localparam logic [2:0] REG_HEIGHT    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_MIN_AREA  = 3'd3;
  localparam logic [2:0] REG_MAX_LABEL = 3'd4;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic [8:0]    width;
    logic [8:0]    height;
    logic [17:0]   threshold;
    logic [16:0]   min_area;
    logic [7:0]    max_label;
    logic [CW-1:0] npix;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] label;
    logic       last;
    logic       ovf;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_READ_WAIT, S_READ_DATA, S_CLEAR,
    S_SCAN_MUL, S_SCAN_RD, S_SCAN_CHK, S_SCAN_NEXT,
    S_POP_RD, S_POP_DAT, S_NB_MUL, S_NB_RD, S_NB_CHK,
    S_DIST0, S_DIST1, S_DIST2, S_DIST_CMP,
    S_LB_RD, S_LB_MUL, S_LB_WR
  } state_t;

  // Neighbor offsets: rows top to bottom, columns left to right
  function automatic logic signed [1:0] dir_dx(input logic [2:0] dir);
    case (dir)
      3'd0, 3'd3, 3'd5: dir_dx = -2'sd1;
      3'd1, 3'd6:       dir_dx = 2'sd0;
      default:          dir_dx = 2'sd1;
    endcase
  endfunction

  function automatic logic signed [1:0] dir_dy(input logic [2:0] dir);
    case (dir)
      3'd0, 3'd1, 3'd2: dir_dy = -2'sd1;
      3'd3, 3'd4:       dir_dy = 2'sd0;
      default:          dir_dy = 2'sd1;
    endcase
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [8:0] clamp_dim(input logic [8:0] v, input logic [8:0] hi);
    if (v == 9'd0) clamp_dim = 9'd1;
    else if (v > hi) clamp_dim = hi;
    else clamp_dim = v;
  endfunction

endpackage
`default_nettype wire

[design/crgl_mac.sv]
// Shared multiply-add unit: registered a*b+c, used for addresses and distances.
// Depends on nothing but the clock.
`default_nettype none
module crgl_mac (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [8:0]  a,
  input  wire logic [8:0]  b,
  input  wire logic [17:0] c,
  output logic      [17:0] p_r
);
  logic [17:0] p_nxt;

  assign p_nxt = ({9'd0, a} * {9'd0, b}) + c;

  always_ff @(posedge clk) begin
    if (en) p_r <= p_nxt;
  end
endmodule
`default_nettype wire

[design/crgl_engine.sv]
// Sequencer, frame memories and region stack of the labeler.
// Depends on crgl_pkg and crgl_mac.
`default_nettype none
module crgl_engine (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire crgl_pkg::cfg_t cfg,
  input  wire logic          in_valid,
  input  wire logic          in_mode,
  input  wire logic [23:0]   in_color,
  output logic               in_ready,
  input  wire logic          out_busy,
  output crgl_pkg::res_t     res
);
  import crgl_pkg::*;

  state_t state_r, state_nxt;

  logic [8:0]    lv_mem [NPIX];
  logic [23:0]   pix_mem [NPIX];
  logic [AW-1:0] st_mem [NPIX];
  logic [8:0]    lv_q_r;
  logic [23:0]   pix_q_r;
  logic [AW-1:0] st_q_r;

  logic          lv_we, lv_re, pix_we, pix_re, st_we, st_re;
  logic [AW-1:0] lv_wa, lv_ra, pix_wa, pix_ra, st_wa, st_ra;
  logic [8:0]    lv_wd;
  logic [AW-1:0] st_wd;

  logic          labelled_r, labelled_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] load_idx_r, load_idx_nxt;
  logic [CW-1:0] read_idx_r, read_idx_nxt;
  logic [CW-1:0] ri_r, ri_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] lab_npix_r, lab_npix_nxt;
  logic [CW-1:0] head_r, head_nxt;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [8:0]    next_label_r, next_label_nxt;
  logic [7:0]    val_r, val_nxt;
  logic [XW-1:0] sx_r, sx_nxt, cx_r, cx_nxt, nx_r, nx_nxt;
  logic [YW-1:0] sy_r, sy_nxt, cy_r, cy_nxt, ny_r, ny_nxt;
  logic [2:0]    dir_r, dir_nxt;
  logic [23:0]   seed_r, seed_nxt;
  logic [AW-1:0] naddr_r, naddr_nxt;

  logic          mac_en;
  logic [8:0]    mac_a, mac_b;
  logic [17:0]   mac_c, mac_p;

  logic signed [1:0] dx_s, dy_s;
  logic signed [9:0] nx_s, ny_s;
  logic              nb_in;
  logic [CW-1:0]     ri_pick, ri_inc;

  crgl_mac u_mac (
    .clk (clk),
    .en  (mac_en),
    .a   (mac_a),
    .b   (mac_b),
    .c   (mac_c),
    .p_r (mac_p)
  );

  always_ff @(posedge clk) begin
    if (lv_we) lv_mem[lv_wa] <= lv_wd;
    if (lv_re) lv_q_r <= lv_mem[lv_ra];
  end

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[pix_wa] <= in_color;
    if (pix_re) pix_q_r <= pix_mem[pix_ra];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_wa] <= st_wd;
    if (st_re) st_q_r <= st_mem[st_ra];
  end

  assign dx_s  = dir_dx(dir_r);
  assign dy_s  = dir_dy(dir_r);
  assign nx_s  = $signed({2'b00, cx_r}) + $signed({{8{dx_s[1]}}, dx_s});
  assign ny_s  = $signed({2'b00, cy_r}) + $signed({{8{dy_s[1]}}, dy_s});
  assign nb_in = !nx_s[9] && !ny_s[9] && (nx_s[8:0] < cfg.width) && (ny_s[8:0] < cfg.height);
  assign ri_pick = (read_idx_r >= cfg.npix) ? '0 : read_idx_r;
  assign ri_inc  = ri_r + 1'b1;
  assign in_ready = (state_r == S_IDLE);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_mode == MODE_READ) begin
          state_nxt = labelled_r ? S_READ_WAIT : S_CLEAR;
        end
      end
      S_READ_WAIT: if (!out_busy) state_nxt = S_READ_DATA;
      S_READ_DATA: state_nxt = S_IDLE;
      S_CLEAR:     if (clr_r == cfg.npix - 1'b1) state_nxt = S_SCAN_MUL;
      S_SCAN_MUL:  state_nxt = S_SCAN_RD;
      S_SCAN_RD:   state_nxt = S_SCAN_CHK;
      S_SCAN_CHK:  state_nxt = (lv_q_r[8:1] != 8'd0) ? S_SCAN_NEXT : S_POP_RD;
      S_SCAN_NEXT: begin
        if (ovf_r || ({1'b0, sy_r} + 9'd1 == cfg.height &&
                      {1'b0, sx_r} + 9'd1 == cfg.width)) begin
          state_nxt = S_READ_WAIT;
        end else begin
          state_nxt = S_SCAN_MUL;
        end
      end
      S_POP_RD:    state_nxt = (head_r == depth_r) ? S_LB_RD : S_POP_DAT;
      S_POP_DAT:   state_nxt = S_NB_MUL;
      S_NB_MUL: begin
        if (nb_in) state_nxt = S_NB_RD;
        else if (dir_r == 3'd7) state_nxt = S_POP_RD;
      end
      S_NB_RD:     state_nxt = S_NB_CHK;
      S_NB_CHK: begin
        if (lv_q_r == 9'd0) state_nxt = S_DIST0;
        else state_nxt = (dir_r == 3'd7) ? S_POP_RD : S_NB_MUL;
      end
      S_DIST0:     state_nxt = S_DIST1;
      S_DIST1:     state_nxt = S_DIST2;
      S_DIST2:     state_nxt = S_DIST_CMP;
      S_DIST_CMP:  state_nxt = (dir_r == 3'd7) ? S_POP_RD : S_NB_MUL;
      S_LB_RD:     state_nxt = (idx_r == depth_r) ? S_SCAN_NEXT : S_LB_MUL;
      S_LB_MUL:    state_nxt = S_LB_WR;
      S_LB_WR:     state_nxt = S_LB_RD;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    labelled_nxt   = labelled_r;
    ovf_nxt        = ovf_r;
    load_idx_nxt   = load_idx_r;
    read_idx_nxt   = read_idx_r;
    ri_nxt         = ri_r;
    clr_nxt        = clr_r;
    lab_npix_nxt   = lab_npix_r;
    head_nxt       = head_r;
    depth_nxt      = depth_r;
    idx_nxt        = idx_r;
    next_label_nxt = next_label_r;
    val_nxt        = val_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    nx_nxt         = nx_r;
    ny_nxt         = ny_r;
    dir_nxt        = dir_r;
    seed_nxt       = seed_r;
    naddr_nxt      = naddr_r;
    lv_we = 1'b0; lv_re = 1'b0; lv_wa = '0; lv_ra = '0; lv_wd = '0;
    pix_we = 1'b0; pix_re = 1'b0; pix_wa = '0; pix_ra = '0;
    st_we = 1'b0; st_re = 1'b0; st_wa = '0; st_ra = '0; st_wd = '0;
    mac_en = 1'b0; mac_a = '0; mac_b = '0; mac_c = '0;
    res = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_mode == MODE_LOAD) begin
          if (labelled_r) begin
            labelled_nxt = 1'b0;
            read_idx_nxt = '0;
            pix_we       = 1'b1;
            pix_wa       = '0;
            load_idx_nxt = CW'(1);
          end else if (load_idx_r < cfg.npix) begin
            pix_we       = 1'b1;
            pix_wa       = load_idx_r[AW-1:0];
            load_idx_nxt = load_idx_r + 1'b1;
          end
        end
        clr_nxt = '0;
      end
      S_READ_WAIT: begin
        labelled_nxt = 1'b1;
        if (!out_busy) begin
          lv_re  = 1'b1;
          lv_ra  = ri_pick[AW-1:0];
          ri_nxt = ri_pick;
        end
      end
      S_READ_DATA: begin
        // Entries past the last labeled frame read as cleared
        res.valid    = 1'b1;
        res.label    = (ri_r < lab_npix_r) ? lv_q_r[8:1] : 8'd0;
        res.last     = (ri_r == cfg.npix - 1'b1);
        res.ovf      = ovf_r;
        read_idx_nxt = (ri_inc >= cfg.npix) ? '0 : ri_inc;
      end
      S_CLEAR: begin
        lv_we   = 1'b1;
        lv_wa   = clr_r[AW-1:0];
        clr_nxt = clr_r + 1'b1;
        lab_npix_nxt = cfg.npix;
        sx_nxt  = '0;
        sy_nxt  = '0;
        next_label_nxt = 9'd1;
        ovf_nxt = 1'b0;
      end
      S_SCAN_MUL: begin
        mac_en = 1'b1;
        mac_a  = {1'b0, sy_r};
        mac_b  = cfg.width;
        mac_c  = {10'd0, sx_r};
      end
      S_SCAN_RD: begin
        lv_re  = 1'b1;
        lv_ra  = mac_p[AW-1:0];
        pix_re = 1'b1;
        pix_ra = mac_p[AW-1:0];
      end
      S_SCAN_CHK: begin
        if (lv_q_r[8:1] == 8'd0) begin
          seed_nxt  = pix_q_r;
          lv_we     = 1'b1;
          lv_wa     = mac_p[AW-1:0];
          lv_wd     = 9'd1;
          st_we     = 1'b1;
          st_wa     = '0;
          st_wd     = {sy_r, sx_r};
          depth_nxt = CW'(1);
          head_nxt  = '0;
        end
      end
      S_SCAN_NEXT: begin
        if ({1'b0, sy_r} + 9'd1 == cfg.height) begin
          sy_nxt = '0;
          sx_nxt = sx_r + 1'b1;
        end else begin
          sy_nxt = sy_r + 1'b1;
        end
      end
      S_POP_RD: begin
        if (head_r == depth_r) begin
          idx_nxt = '0;
          if (depth_r > {{(CW-17){1'b0}}, cfg.min_area}) begin
            val_nxt        = next_label_r[7:0];
            next_label_nxt = next_label_r + 1'b1;
            if (next_label_r + 1'b1 > {1'b0, cfg.max_label}) ovf_nxt = 1'b1;
          end else begin
            val_nxt = SMALL_MARK;
          end
        end else begin
          st_re    = 1'b1;
          st_ra    = head_r[AW-1:0];
          head_nxt = head_r + 1'b1;
        end
      end
      S_POP_DAT: begin
        cx_nxt  = st_q_r[XW-1:0];
        cy_nxt  = st_q_r[AW-1:XW];
        dir_nxt = '0;
      end
      S_NB_MUL: begin
        if (nb_in) begin
          nx_nxt = nx_s[XW-1:0];
          ny_nxt = ny_s[YW-1:0];
          mac_en = 1'b1;
          mac_a  = {1'b0, ny_s[YW-1:0]};
          mac_b  = cfg.width;
          mac_c  = {10'd0, nx_s[XW-1:0]};
        end else begin
          dir_nxt = dir_r + 1'b1;
        end
      end
      S_NB_RD: begin
        naddr_nxt = mac_p[AW-1:0];
        lv_re     = 1'b1;
        lv_ra     = mac_p[AW-1:0];
        pix_re    = 1'b1;
        pix_ra    = mac_p[AW-1:0];
      end
      S_NB_CHK: begin
        if (lv_q_r != 9'd0) dir_nxt = dir_r + 1'b1;
      end
      S_DIST0: begin
        mac_en = 1'b1;
        mac_a  = {1'b0, abs_diff(seed_r[7:0], pix_q_r[7:0])};
        mac_b  = mac_a;
      end
      S_DIST1: begin
        mac_en = 1'b1;
        mac_a  = {1'b0, abs_diff(seed_r[15:8], pix_q_r[15:8])};
        mac_b  = mac_a;
        mac_c  = mac_p;
      end
      S_DIST2: begin
        mac_en = 1'b1;
        mac_a  = {1'b0, abs_diff(seed_r[23:16], pix_q_r[23:16])};
        mac_b  = mac_a;
        mac_c  = mac_p;
      end
      S_DIST_CMP: begin
        dir_nxt = dir_r + 1'b1;
        if (mac_p < cfg.threshold) begin
          lv_we     = 1'b1;
          lv_wa     = naddr_r;
          lv_wd     = 9'd1;
          st_we     = 1'b1;
          st_wa     = depth_r[AW-1:0];
          st_wd     = {ny_r, nx_r};
          depth_nxt = depth_r + 1'b1;
        end
      end
      S_LB_RD: begin
        if (idx_r != depth_r) begin
          st_re = 1'b1;
          st_ra = idx_r[AW-1:0];
        end
      end
      S_LB_MUL: begin
        mac_en  = 1'b1;
        mac_a   = {1'b0, st_q_r[AW-1:XW]};
        mac_b   = cfg.width;
        mac_c   = {10'd0, st_q_r[XW-1:0]};
        idx_nxt = idx_r + 1'b1;
      end
      S_LB_WR: begin
        lv_we = 1'b1;
        lv_wa = mac_p[AW-1:0];
        lv_wd = {val_r, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      labelled_r   <= 1'b0;
      ovf_r        <= 1'b0;
      load_idx_r   <= '0;
      read_idx_r   <= '0;
      lab_npix_r   <= '0;
      next_label_r <= 9'd1;
      depth_r      <= '0;
      head_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      labelled_r   <= labelled_nxt;
      ovf_r        <= ovf_nxt;
      load_idx_r   <= load_idx_nxt;
      read_idx_r   <= read_idx_nxt;
      lab_npix_r   <= lab_npix_nxt;
      next_label_r <= next_label_nxt;
      depth_r      <= depth_nxt;
      head_r       <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ri_r    <= ri_nxt;
    clr_r   <= clr_nxt;
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    sx_r    <= sx_nxt;
    sy_r    <= sy_nxt;
    cx_r    <= cx_nxt;
    cy_r    <= cy_nxt;
    nx_r    <= nx_nxt;
    ny_r    <= ny_nxt;
    dir_r   <= dir_nxt;
    seed_r  <= seed_nxt;
    naddr_r <= naddr_nxt;
  end

  a_res_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> !out_busy) else $error("result raised while output slot full");
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CW'(NPIX)) else $error("region stack overrun");
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP_RD) |-> (head_r <= depth_r)) else $error("pop beyond stack top");
  a_label: assert property (@(posedge clk) disable iff (!rst_n)
    next_label_r <= 9'd256) else $error("label counter ran past last label");
endmodule
`default_nettype wire

[design/color_region_growing_labeler_top.sv]
// Top level of the color region growing labeler: register port, stream ports,
// output register. Depends on crgl_pkg, crgl_engine and crgl_mac.
//
// Usage: write geometry, color threshold, minimum area and last label on the
// APB port while the block is idle. Send a frame of BGR pixels in row-major
// order as mode-0 words on the in_ stream; each load is accepted in idle and
// gives no result. The first mode-1 word after loading labels the whole frame
// (8-connected region growing seeded column by column), then every mode-1
// word returns one label in row-major order on the out_ stream, with tlast on
// the final pixel and tuser set when labels ran out.
// A read of a labeled frame passes the read-wait and read-data states to the
// output register; in_tready returns in idle, so reads do not overlap.
// Labeling makes a clearing pass over width*height entries of the label
// memory, then per scanned pixel a multiply, read and check; per region pixel
// a stack pop, per neighbor a skip off the frame edge, a read and check when
// already taken, or else three passes of the shared multiply-add for the
// squared distance and a compare; last the label is written back per pixel.
// in_tready is low while an item is in work. When the receiver stalls, the
// result waits in the output register; loads are still taken, the next read
// waits for the slot. Reset empties the output register and restores the
// register defaults; the frame memories keep their contents.
`default_nettype none
module color_region_growing_labeler_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: blue[7:0], green[15:8], red[23:16]
  input  wire logic [23:0] in_tdata,
  // in_tuser: mode[0]
  input  wire logic        in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: label[7:0]
  output logic      [7:0]  out_tdata,
  // out_tuser: region_overflow[0]
  output logic             out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  import crgl_pkg::*;

  logic [8:0]  width_r, width_nxt, height_r, height_nxt;
  logic [17:0] thr_r, thr_nxt;
  logic [16:0] area_r, area_nxt;
  logic [7:0]  maxl_r, maxl_nxt;
  logic        wr_en;
  logic [2:0]  reg_idx;

  logic        ovalid_r, ovalid_nxt;
  logic [7:0]  olabel_r, olabel_nxt;
  logic        olast_r, olast_nxt, oovf_r, oovf_nxt;

  cfg_t        cfg;
  res_t        res;
  logic        eng_ready;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[4:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // Register writes
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    thr_nxt    = thr_r;
    area_nxt   = area_r;
    maxl_nxt   = maxl_r;
    if (wr_en) begin
      case (reg_idx)
        REG_WIDTH:     width_nxt  = cfg_pwdata[8:0];
        REG_HEIGHT:    height_nxt = cfg_pwdata[8:0];
        REG_THRESHOLD: thr_nxt    = cfg_pwdata[17:0];
        REG_MIN_AREA:  area_nxt   = cfg_pwdata[16:0];
        REG_MAX_LABEL: maxl_nxt   = cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register reads return the written value cut to the field width, unsaturated
  always_comb begin
    case (reg_idx)
      REG_WIDTH:     cfg_prdata = {23'd0, width_r};
      REG_HEIGHT:    cfg_prdata = {23'd0, height_r};
      REG_THRESHOLD: cfg_prdata = {14'd0, thr_r};
      REG_MIN_AREA:  cfg_prdata = {15'd0, area_r};
      REG_MAX_LABEL: cfg_prdata = {24'd0, maxl_r};
      default:       cfg_prdata = '0;
    endcase
  end

  // Saturate geometry and form the pixel count
  always_comb begin
    cfg.width     = clamp_dim(width_r, 9'(MAX_WIDTH));
    cfg.height    = clamp_dim(height_r, 9'(MAX_HEIGHT));
    cfg.threshold = thr_r;
    cfg.min_area  = area_r;
    cfg.max_label = maxl_r;
    cfg.npix      = CW'({9'd0, cfg.width} * {9'd0, cfg.height});
  end

  crgl_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_mode  (in_tuser),
    .in_color (in_tdata),
    .in_ready (eng_ready),
    .out_busy (ovalid_r),
    .res      (res)
  );

  assign in_tready = eng_ready;

  // Output register: hold the word until taken, load a new one when raised
  always_comb begin
    ovalid_nxt = ovalid_r;
    olabel_nxt = olabel_r;
    olast_nxt  = olast_r;
    oovf_nxt   = oovf_r;
    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;
    if (res.valid) begin
      ovalid_nxt = 1'b1;
      olabel_nxt = res.label;
      olast_nxt  = res.last;
      oovf_nxt   = res.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'(MAX_WIDTH);
      height_r <= 9'(MAX_HEIGHT);
      thr_r    <= 18'd200;
      area_r   <= 17'd65;
      maxl_r   <= 8'd100;
      ovalid_r <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      thr_r    <= thr_nxt;
      area_r   <= area_nxt;
      maxl_r   <= maxl_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    olabel_r <= olabel_nxt;
    olast_r  <= olast_nxt;
    oovf_r   <= oovf_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = olabel_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oovf_r;
endmodule
`default_nettype wire

[verif/color_region_growing_labeler_top_tb.sv]
// Self-checking testbench for color_region_growing_labeler_top: stream-driven
// frame loads and label reads, APB setup, and a built-in labeling predictor.
// Depends on crgl_pkg and the design files under design/.
`default_nettype none
module color_region_growing_labeler_top_tb;
  import crgl_pkg::*;

  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE      = 40;

  typedef struct {
    bit [7:0] lab;
    bit       last;
    bit       ovf;
  } label_word_t;

  typedef enum {ROW_CFG, ROW_LOAD, ROW_READ} row_kind_t;

  typedef struct {
    row_kind_t  kind;
    logic [2:0] reg_idx;
    bit [31:0]  val;
    bit         typed;
    bit [7:0]   lab;
    bit         last;
    bit         ovf;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  color_region_growing_labeler_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tuser(in_tuser), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // ---------------------------------------------------------------------
  // Labeling predictor: frame memories, region grower and readout pointer
  // ---------------------------------------------------------------------
  bit [23:0]   pix_mem  [NPIX];
  bit [7:0]    lbl_mem  [NPIX];
  bit          mark_mem [NPIX];
  int unsigned grow_list[NPIX];

  int unsigned img_w = 256, img_h = 256, thr = 200, min_px = 65, top_label = 100;
  int unsigned load_ptr, read_ptr;
  bit          frame_labeled, labels_ran_out;

  label_word_t pending_labels[$];   // expected words, oldest first
  int          fail_count, mismatch_count, item_count;
  bit          idle_on = 1'b1;
  bit          choke;                // ask the receiver for one long hold-off

  function automatic int unsigned clamp_geom(int unsigned v);
    v = v & 32'h1FF;
    if (v == 0) return 1;
    if (v > 256) return 256;
    return v;
  endfunction

  function automatic int unsigned color_gap(bit [23:0] a, bit [23:0] b);
    int unsigned s;
    int d;
    s = 0;
    for (int k = 0; k < 3; k++) begin
      d = int'(a[8*k +: 8]) - int'(b[8*k +: 8]);
      s += d * d;
    end
    return s;
  endfunction

  function automatic void apply_setting(logic [2:0] idx, bit [31:0] v);
    case (idx)
      REG_WIDTH:     img_w     = clamp_geom(v);
      REG_HEIGHT:    img_h     = clamp_geom(v);
      REG_THRESHOLD: thr       = v & 32'h3FFFF;
      REG_MIN_AREA:  min_px    = v & 32'h1FFFF;
      REG_MAX_LABEL: top_label = v & 32'hFF;
      default: ;
    endcase
  endfunction

  // Flood one region from seed; returns its pixel count, members in grow_list
  function automatic int unsigned grow_from(int unsigned seed);
    int unsigned head, depth, c, n;
    int cx, cy, nx, ny;
    bit [23:0] seed_col;
    head = 0;
    depth = 0;
    seed_col = pix_mem[seed];
    mark_mem[seed] = 1'b1;
    grow_list[depth++] = seed;
    while (head < depth) begin
      c = grow_list[head++];
      cx = c % img_w;
      cy = c / img_w;
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dx = -1; dx <= 1; dx++) begin
          nx = cx + dx;
          ny = cy + dy;
          if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 &&
              nx < int'(img_w) && ny < int'(img_h)) begin
            n = ny * img_w + nx;
            if (lbl_mem[n] == 0 && !mark_mem[n] &&
                color_gap(seed_col, pix_mem[n]) < thr) begin
              mark_mem[n] = 1'b1;
              grow_list[depth++] = n;
            end
          end
        end
      end
    end
    return depth;
  endfunction

  function automatic void label_frame_model();
    int unsigned area, next_lab, p;
    bit [7:0] v;
    for (int i = 0; i < NPIX; i++) begin
      lbl_mem[i] = 0;
      mark_mem[i] = 0;
    end
    next_lab = 1;
    labels_ran_out = 0;
    // scan column by column, each column top to bottom
    for (int unsigned x = 0; x < img_w && !labels_ran_out; x++) begin
      for (int unsigned y = 0; y < img_h && !labels_ran_out; y++) begin
        p = y * img_w + x;
        if (lbl_mem[p] == 0) begin
          area = grow_from(p);
          if (area > min_px) begin
            v = next_lab[7:0];
            next_lab++;
            if (next_lab > top_label) labels_ran_out = 1;
          end else begin
            v = SMALL_MARK;
          end
          for (int unsigned i = 0; i < area; i++) begin
            lbl_mem[grow_list[i]] = v;
            mark_mem[grow_list[i]] = 0;
          end
        end
      end
    end
    frame_labeled = 1;
  endfunction

  function automatic bit predict_word(bit mode, bit [23:0] bgr, output label_word_t r);
    int unsigned npx;
    npx = img_w * img_h;
    r = '{default: 0};
    if (mode == MODE_LOAD) begin
      if (frame_labeled) begin
        frame_labeled = 0;
        load_ptr = 0;
        read_ptr = 0;
      end
      if (load_ptr < npx) pix_mem[load_ptr++] = bgr;
      return 0;
    end
    if (!frame_labeled) label_frame_model();
    if (read_ptr >= npx) read_ptr = 0;
    r.lab  = lbl_mem[read_ptr];
    r.last = (read_ptr == npx - 1);
    r.ovf  = labels_ran_out;
    read_ptr++;
    if (read_ptr >= npx) read_ptr = 0;
    return 1;
  endfunction

  // ---------------------------------------------------------------------
  // Sender side: one word per call, random gaps, predictor updated on accept
  // ---------------------------------------------------------------------
  task automatic send_word(bit mode, bit [23:0] bgr, bit typed = 0,
                           label_word_t typed_res = '{default: 0});
    label_word_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= bgr;
    do @(posedge clk); while (!in_tready);
    if (predict_word(mode, bgr, r)) pending_labels.push_back(typed ? typed_res : r);
    item_count++;
    @(negedge clk);
  endtask

  // Drain all results, let a trailing load settle, then do an APB write
  task automatic write_reg(logic [2:0] idx, bit [31:0] v);
    in_tvalid <= 1'b0;
    while (pending_labels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    apply_setting(idx, v);
  endtask

  // ---------------------------------------------------------------------
  // Receiver side: random stalls plus one long hold-off on request
  // ---------------------------------------------------------------------
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (choke) begin
        // hold off once a word is waiting, so the output slot and input back up
        out_tready <= 1'b0;
        while (!out_tvalid) @(negedge clk);
        repeat (400) @(negedge clk);
        out_tready <= 1'b1;
        choke = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    label_word_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_labels.size() == 0) begin
        fail_count++;
        if (mismatch_count++ < 10)
          $display("unexpected word: label=%0d last=%0b ovf=%0b",
                   out_tdata, out_tlast, out_tuser);
      end else begin
        e = pending_labels.pop_front();
        if (out_tdata !== e.lab || out_tlast !== e.last || out_tuser !== e.ovf) begin
          fail_count++;
          if (mismatch_count++ < 10)
            $display("label mismatch: exp %0d/%0b/%0b got %0d/%0b/%0b",
                     e.lab, e.last, e.ovf, out_tdata, out_tlast, out_tuser);
        end
      end
    end
  end

  // Watchdog
  int unsigned cycle_count;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Directed rows: two-by-two frames with hand-derived labels
  // ---------------------------------------------------------------------
  stim_row_t directed_rows[] = '{
    '{ROW_CFG, REG_WIDTH, 2, 0, 0, 0, 0},
    '{ROW_CFG, REG_HEIGHT, 2, 0, 0, 0, 0},
    '{ROW_CFG, REG_THRESHOLD, 1, 0, 0, 0, 0},
    '{ROW_CFG, REG_MIN_AREA, 0, 0, 0, 0, 0},
    '{ROW_CFG, REG_MAX_LABEL, 254, 0, 0, 0, 0},
    // left column black, right column white: two regions
    '{ROW_LOAD, REG_WIDTH, 32'h000000, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'hFFFFFF, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'h000000, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'hFFFFFF, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'h123456, 0, 0, 0, 0},  // past the frame: dropped
    '{ROW_READ, REG_WIDTH, 0, 1, 1, 0, 0},
    '{ROW_READ, REG_WIDTH, 0, 1, 2, 0, 0},
    '{ROW_READ, REG_WIDTH, 0, 1, 1, 0, 0},
    '{ROW_READ, REG_WIDTH, 0, 1, 2, 1, 0},
    '{ROW_READ, REG_WIDTH, 0, 1, 1, 0, 0},            // readout wraps
    // one label allowed: second region stays unlabeled
    '{ROW_CFG, REG_MAX_LABEL, 1, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'h000000, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'hFFFFFF, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'h000000, 0, 0, 0, 0},
    '{ROW_LOAD, REG_WIDTH, 32'hFFFFFF, 0, 0, 0, 0},
    '{ROW_READ, REG_WIDTH, 0, 1, 1, 0, 1},
    '{ROW_READ, REG_WIDTH, 0, 1, 0, 0, 1},
    '{ROW_READ, REG_WIDTH, 0, 1, 1, 0, 1},
    '{ROW_READ, REG_WIDTH, 0, 1, 0, 1, 1}
  };

  // Random frame: palette colors with small noise so regions actually grow, or random colors when noisy
  task automatic run_frame(int unsigned w, int unsigned h, bit [31:0] t, bit [31:0] m,
                           bit [31:0] top, bit noisy, bit squeeze);
    bit [23:0] palette[4];
    int unsigned npx, ncol;
    bit [23:0] px;
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_MIN_AREA, m);
    write_reg(REG_MAX_LABEL, top);
    npx = img_w * img_h;
    ncol = $urandom_range(1, 4);
    foreach (palette[i]) palette[i] = $urandom;
    for (int unsigned i = 0; i < npx + $urandom_range(0, 2); i++) begin
      px = palette[$urandom_range(0, ncol - 1)] ^ {5'd0, 3'($urandom), 5'd0,
                                                   3'($urandom), 5'd0, 3'($urandom)};
      send_word(MODE_LOAD, noisy ? 24'($urandom) : px);
    end
    if (squeeze) choke = 1;
    for (int unsigned i = 0; i < npx + $urandom_range(0, 3); i++)
      send_word(MODE_READ, 24'($urandom));
  endtask

  function automatic bit [31:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 1;
      2: return 195076;
      3: return 32'h3FFFF;
      default: return $urandom_range(20, 3000);
    endcase
  endfunction

  function automatic bit [31:0] pick_min_area();
    case ($urandom_range(0, 6))
      0: return 65536;
      1: return 32'h1FFFF;
      2: return 0;
      default: return $urandom_range(0, 6);
    endcase
  endfunction

  function automatic bit [31:0] pick_top_label();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return 254;
      3: return 255;
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  initial begin
    label_word_t tr;
    int unsigned frame_no;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tuser    = 1'b0;
    in_tdata    = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    choke       = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      tr = '{directed_rows[i].lab, directed_rows[i].last, directed_rows[i].ovf};
      case (directed_rows[i].kind)
        ROW_CFG:  write_reg(directed_rows[i].reg_idx, directed_rows[i].val);
        ROW_LOAD: send_word(MODE_LOAD, directed_rows[i].val[23:0]);
        default:  send_word(MODE_READ, 24'hFFFFFF, directed_rows[i].typed, tr);
      endcase
    end

    // Geometry shrink on a labeled frame: reads wrap inside the new size
    write_reg(REG_WIDTH, 1);
    repeat (3) send_word(MODE_READ, 24'h0);

    // Full-width strip with width saturation, then zero geometry saturation
    run_frame(300, 1, 300, 2, 254, 0, 0);
    run_frame(1, 0, 195076, 65536, 255, 0, 0);
    run_frame(0, 9, 32'h3FFFF, 0, 0, 1, 0);

    frame_no = 0;
    while (item_count < 900 + 25) begin
      if (item_count > 800) idle_on = 0;
      run_frame($urandom_range(1, 12), $urandom_range(1, 12), pick_threshold(),
                pick_min_area(), pick_top_label(), $urandom_range(0, 7) == 0,
                frame_no == 2);
      frame_no++;
    end

    in_tvalid <= 1'b0;
    while (pending_labels.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
